// File: sv/cbr_pkg.sv
// Shared types, constants and table builders for the camera basis rotation core.
package cbr_pkg;

    // Vector format and iteration count
    localparam int VW        = 32;             // stored vector width, Q3.(VW-4)
    localparam int FRAC      = VW - 4;
    localparam int IW        = VW + 3;         // working width inside the rotator
    localparam int CORDIC_STEPS = 24;
    localparam int STEP_W    = $clog2(CORDIC_STEPS);

    // Input, gain and angle formats
    localparam int DELTA_W   = 13;
    localparam int GAIN_W    = 24;
    localparam int ANGLE_W   = DELTA_W + GAIN_W;   // exact product width
    localparam int ZW        = 38;                 // angle accumulator width
    localparam int OUT_W     = 32;

    // Gain compensation constant, processed one bit per cycle
    localparam int K_BITS    = 32;
    localparam int KIDX_W    = $clog2(K_BITS);
    localparam logic [K_BITS-1:0] K_CONST = 32'h9B74EDA8;

    // Sequencer counter covers the longer of the two serial phases
    localparam int MAXC      = (K_BITS > CORDIC_STEPS) ? K_BITS : CORDIC_STEPS;
    localparam int CNT_W     = $clog2(MAXC);

    // Angle limits in units of 2^-32 rad
    localparam logic signed [ZW-1:0] PI_ANGLE      = ZW'(64'sh3243F6A88);
    localparam logic signed [ZW-1:0] HALF_PI_ANGLE = ZW'(64'sh1921FB544);
    localparam logic signed [63:0]   QUARTER_PI    = 64'shC90FDAA2;

    // Reset values of the vectors
    localparam logic signed [63:0] ONE_FIX_L     = 64'sd1 <<< FRAC;
    localparam logic signed [63:0] PLANE_RESET_L = (64'sd66 * ONE_FIX_L + 64'sd50) / 64'sd100;
    localparam logic signed [VW-1:0] HEADING_X_RST = VW'(-ONE_FIX_L);
    localparam logic signed [VW-1:0] PLANE_Y_RST   = VW'(PLANE_RESET_L);

    // Output alignment to Q3.28
    localparam int OUT_RSH = (VW > OUT_W) ? VW - OUT_W : 0;
    localparam int OUT_LSH = (VW < OUT_W) ? OUT_W - VW : 0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_QUAD,
        ST_ROT,
        ST_DONE
    } cbr_state_t;

    // Sequencer controls fanned out to the datapath units
    typedef struct packed {
        logic             start;       // capture a new request
        logic             scale_step;  // one bit of the serial multipliers
        logic             angle_step;  // one gain bit of the angle product
        logic             angle_last;  // register the clamped angle
        logic             rot_load;    // quadrant pre-rotation and load
        logic             rot_step;    // one micro-rotation
        logic [CNT_W-1:0] idx;         // current bit or step index
    } cbr_ctrl_t;

    typedef logic signed [ZW-1:0] atan_tab_t [CORDIC_STEPS];

    // Shift-subtract quotient, used only while building constants
    function automatic logic [63:0] cdiv(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) in 2^-32 rad from the truncated series in 2^-60 units
    function automatic logic signed [63:0] atan_entry(input int i);
        logic signed [63:0] sum;
        logic signed [63:0] term;
        int e;
        sum = '0;
        if (i == 0) begin
            return QUARTER_PI;
        end
        for (int k = 0; k < 31; k++) begin
            if (i * (2 * k + 1) <= 60) begin
                e    = 60 - i * (2 * k + 1);
                term = $signed(cdiv(64'd1 << e, 64'(2 * k + 1)));
                sum  = (k % 2 == 1) ? sum - term : sum + term;
            end
        end
        return (sum + (64'sd1 <<< 27)) >>> 28;
    endfunction

    function automatic atan_tab_t build_atan_tab();
        atan_tab_t t;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            t[i] = ZW'(atan_entry(i));
        end
        return t;
    endfunction

    localparam atan_tab_t ATAN_TAB = build_atan_tab();

    // Saturate a working value to the stored vector range
    function automatic logic signed [VW-1:0] clamp_vec(input logic signed [IW-1:0] v);
        logic signed [IW-1:0] hi;
        logic signed [IW-1:0] lo;
        hi = IW'({1'b0, {(VW-1){1'b1}}});
        lo = -hi - IW'(1);
        if (v > hi) begin
            return hi[VW-1:0];
        end else if (v < lo) begin
            return lo[VW-1:0];
        end
        return v[VW-1:0];
    endfunction

    // Stored vector to Q3.28 output bits
    function automatic logic [OUT_W-1:0] to_output(input logic signed [VW-1:0] v);
        logic signed [VW+OUT_W-1:0] ext;
        ext = (VW + OUT_W)'(v);
        ext = (ext >>> OUT_RSH) <<< OUT_LSH;
        return ext[OUT_W-1:0];
    endfunction

endpackage

// File: sv/cbr_kscale.sv
// Bit-serial gain compensation: rounds |v| * K / 2^32, sign restored after.
module cbr_kscale
    import cbr_pkg::*;
(
    input  logic                 aclk,
    input  cbr_ctrl_t            ctrl,
    input  logic signed [VW-1:0] value_in,
    output logic signed [IW-1:0] value_out
);

    logic          neg_reg;
    logic [VW-1:0] mag_reg;
    logic [VW-1:0] acc_reg;
    logic [VW-1:0] acc_next;
    logic [VW:0]   sum;
    logic          kbit;
    logic          last;

    // Magnitude of the component and its sign
    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            neg_reg <= value_in[VW-1];
            mag_reg <= value_in[VW-1] ? VW'(-value_in) : VW'(value_in);
        end
    end

    // One bit of K per cycle, LSB first; rounding term joins on the top bit
    always_comb begin
        kbit     = K_CONST[ctrl.idx[KIDX_W-1:0]];
        last     = (ctrl.idx[KIDX_W-1:0] == KIDX_W'(K_BITS - 1));
        sum      = {1'b0, acc_reg} + (kbit ? {1'b0, mag_reg} : '0) + (VW+1)'(last);
        acc_next = sum[VW:1];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            acc_reg <= '0;
        end else if (ctrl.scale_step) begin
            acc_reg <= acc_next;
        end
    end

    assign value_out = neg_reg ? -$signed({{(IW-VW){1'b0}}, acc_reg})
                               :  $signed({{(IW-VW){1'b0}}, acc_reg});

endmodule

// File: sv/cbr_angle.sv
// Bit-serial delta * gain product, then clamp to plus or minus pi.
module cbr_angle
    import cbr_pkg::*;
(
    input  logic                      aclk,
    input  cbr_ctrl_t                 ctrl,
    input  logic signed [DELTA_W-1:0] delta_in,
    input  logic [GAIN_W-1:0]         gain_in,
    output logic signed [ZW-1:0]      angle_out
);

    logic signed [DELTA_W-1:0] delta_reg;
    logic [GAIN_W-1:0]         gain_reg;
    logic signed [ANGLE_W-1:0] acc_reg;
    logic signed [ANGLE_W-1:0] acc_next;
    logic signed [ZW-1:0]      prod;
    logic signed [ZW-1:0]      angle_reg;

    // Gain bits leave MSB first; product doubles and adds on each angle step
    assign acc_next = (acc_reg <<< 1)
                    + (gain_reg[GAIN_W-1] ? ANGLE_W'(delta_reg) : '0);

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            delta_reg <= delta_in;
            gain_reg  <= gain_in;
            acc_reg   <= '0;
        end else if (ctrl.angle_step) begin
            gain_reg  <= gain_reg << 1;
            acc_reg   <= acc_next;
        end
    end

    // Clamp the finished product
    assign prod = ZW'(acc_reg);

    always_ff @(posedge aclk) begin
        if (ctrl.angle_last) begin
            if (prod > PI_ANGLE) begin
                angle_reg <= PI_ANGLE;
            end else if (prod < -PI_ANGLE) begin
                angle_reg <= -PI_ANGLE;
            end else begin
                angle_reg <= prod;
            end
        end
    end

    assign angle_out = angle_reg;

endmodule

// File: sv/cbr_cordic.sv
// Shared CORDIC rotator: quadrant pre-rotation, then one micro-rotation per cycle.
module cbr_cordic
    import cbr_pkg::*;
(
    input  logic                 aclk,
    input  cbr_ctrl_t            ctrl,
    input  logic signed [IW-1:0] hx_in,
    input  logic signed [IW-1:0] hy_in,
    input  logic signed [IW-1:0] px_in,
    input  logic signed [IW-1:0] py_in,
    input  logic signed [ZW-1:0] angle_in,
    output logic signed [VW-1:0] hx_out,
    output logic signed [VW-1:0] hy_out,
    output logic signed [VW-1:0] px_out,
    output logic signed [VW-1:0] py_out
);

    logic signed [IW-1:0] hx_reg, hy_reg, px_reg, py_reg;
    logic signed [ZW-1:0] z_reg;
    logic [STEP_W-1:0]    step;
    logic                 pos;
    logic signed [ZW-1:0] atan_i;

    assign step   = ctrl.idx[STEP_W-1:0];
    assign pos    = !z_reg[ZW-1];
    assign atan_i = ATAN_TAB[step];

    always_ff @(posedge aclk) begin
        if (ctrl.rot_load) begin
            // Quadrant pre-rotation by plus or minus pi/2
            if (angle_in > HALF_PI_ANGLE) begin
                hx_reg <= -hy_in;  hy_reg <= hx_in;
                px_reg <= -py_in;  py_reg <= px_in;
                z_reg  <= angle_in - HALF_PI_ANGLE;
            end else if (angle_in < -HALF_PI_ANGLE) begin
                hx_reg <= hy_in;   hy_reg <= -hx_in;
                px_reg <= py_in;   py_reg <= -px_in;
                z_reg  <= angle_in + HALF_PI_ANGLE;
            end else begin
                hx_reg <= hx_in;   hy_reg <= hy_in;
                px_reg <= px_in;   py_reg <= py_in;
                z_reg  <= angle_in;
            end
        end else if (ctrl.rot_step) begin
            // Micro-rotation, direction set by the residual angle sign
            if (pos) begin
                hx_reg <= hx_reg - (hy_reg >>> step);
                hy_reg <= hy_reg + (hx_reg >>> step);
                px_reg <= px_reg - (py_reg >>> step);
                py_reg <= py_reg + (px_reg >>> step);
                z_reg  <= z_reg - atan_i;
            end else begin
                hx_reg <= hx_reg + (hy_reg >>> step);
                hy_reg <= hy_reg - (hx_reg >>> step);
                px_reg <= px_reg + (py_reg >>> step);
                py_reg <= py_reg - (px_reg >>> step);
                z_reg  <= z_reg + atan_i;
            end
        end
    end

    assign hx_out = clamp_vec(hx_reg);
    assign hy_out = clamp_vec(hy_reg);
    assign px_out = clamp_vec(px_reg);
    assign py_out = clamp_vec(py_reg);

endmodule

// File: sv/camera_basis_rotation_core.sv
// Top level: camera direction and plane rotation by mouse delta.
//
//  Channel   Ports              Payload
//  input     s_tvalid/tready    s_tdata[12:0] mouse_delta (16 bits)
//  result    m_tvalid/tready    m_tdata: dir_x, dir_y, plane_x, plane_y (128 bits)
//  config    cfg_valid/ready    cfg_data[23:0] rotation_gain
//
//  One request passes through the accept cycle, the bit-serial gain compensation and
//  angle product, the quadrant pre-rotation, the CORDIC micro-rotations and the
//  write-back.
//  Reset is synchronous, active low, and restores the vectors and the gain.
//  A finished result waits in the output register; a new request is taken meanwhile,
//  and write-back stalls only if the previous result has still not been taken.
module camera_basis_rotation_core
    import cbr_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [15:0]   s_tdata,    // [12:0] mouse_delta
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [127:0]  m_tdata,    // [31:0] new_dir_x, [63:32] new_dir_y,
                                      // [95:64] new_plane_x, [127:96] new_plane_y
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [23:0]   cfg_data    // [23:0] rotation_gain
);

    cbr_state_t           state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    cbr_ctrl_t            ctrl;
    logic [GAIN_W-1:0]    gain_reg;
    logic signed [VW-1:0] hx_reg, hy_reg, px_reg, py_reg;
    logic signed [IW-1:0] hx_s, hy_s, px_s, py_s;
    logic signed [ZW-1:0] angle;
    logic signed [VW-1:0] hx_r, hy_r, px_r, py_r;
    logic                 m_tvalid_reg;
    logic [127:0]         m_tdata_reg;
    logic                 s_acc;
    logic                 out_free;
    logic                 wb;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    // Gain register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= GAIN_W'(2147484);
        end else if (cfg_valid && cfg_ready) begin
            gain_reg <= cfg_data;
        end
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        ctrl            = '0;
        ctrl.idx        = cnt_reg;
        wb              = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                ctrl.start = s_acc;
                if (s_acc) begin
                    state_next = ST_SCALE;
                    cnt_next   = '0;
                end
            end
            ST_SCALE: begin
                ctrl.scale_step = 1'b1;
                ctrl.angle_step = (32'(cnt_reg) < GAIN_W);
                cnt_next        = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(K_BITS - 1)) begin
                    ctrl.angle_last = 1'b1;
                    state_next      = ST_QUAD;
                    cnt_next        = '0;
                end
            end
            ST_QUAD: begin
                ctrl.rot_load = 1'b1;
                state_next    = ST_ROT;
                cnt_next      = '0;
            end
            ST_ROT: begin
                ctrl.rot_step = 1'b1;
                cnt_next      = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(CORDIC_STEPS - 1)) begin
                    state_next = ST_DONE;
                    cnt_next   = '0;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    wb         = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Gain compensation lanes
    cbr_kscale u_ks_hx (.aclk(aclk), .ctrl(ctrl), .value_in(hx_reg), .value_out(hx_s));
    cbr_kscale u_ks_hy (.aclk(aclk), .ctrl(ctrl), .value_in(hy_reg), .value_out(hy_s));
    cbr_kscale u_ks_px (.aclk(aclk), .ctrl(ctrl), .value_in(px_reg), .value_out(px_s));
    cbr_kscale u_ks_py (.aclk(aclk), .ctrl(ctrl), .value_in(py_reg), .value_out(py_s));

    cbr_angle u_angle (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .delta_in  ($signed(s_tdata[DELTA_W-1:0])),
        .gain_in   (gain_reg),
        .angle_out (angle)
    );

    cbr_cordic u_cordic (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .hx_in    (hx_s),
        .hy_in    (hy_s),
        .px_in    (px_s),
        .py_in    (py_s),
        .angle_in (angle),
        .hx_out   (hx_r),
        .hy_out   (hy_r),
        .px_out   (px_r),
        .py_out   (py_r)
    );

    // Vector state, written back after rotation
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hx_reg <= HEADING_X_RST;
            hy_reg <= '0;
            px_reg <= '0;
            py_reg <= PLANE_Y_RST;
        end else if (wb) begin
            hx_reg <= hx_r;
            hy_reg <= hy_r;
            px_reg <= px_r;
            py_reg <= py_r;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (wb) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wb) begin
            m_tdata_reg <= {to_output(py_r), to_output(px_r),
                            to_output(hy_r), to_output(hx_r)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks
    a_start_scale: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> state_reg == ST_SCALE && cnt_reg == '0)
        else $error("request did not start the scale phase");

    a_rot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ROT |-> 32'(cnt_reg) < CORDIC_STEPS)
        else $error("micro-rotation index out of range");

    a_wb_out: assert property (@(posedge aclk) disable iff (!aresetn)
        wb |=> m_tvalid_reg && state_reg == ST_IDLE)
        else $error("write-back did not present a result");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |-> !wb)
        else $error("pending result overwritten");

endmodule
